// ===== src/psfp_pkg.sv =====
// Shared constants, types and helpers for the particle sensor frame parser.
// No dependencies; imported by every module of the block.
package psfp_pkg;

   localparam int PAYLOAD_BYTES = 26;
   localparam int PB_IDX_W      = $clog2(PAYLOAD_BYTES);
   localparam int WORD_COUNT    = 13;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  START_FIRST  = 8'h42;
   localparam logic [7:0]  START_SECOND = 8'h4D;
   localparam logic [15:0] LEN_SHORT    = 16'(2 * 9 + 2);
   localparam logic [15:0] LEN_LONG     = 16'(2 * 13 + 2);

   // frame position codes
   localparam logic [4:0] POS_START1 = 5'd0;
   localparam logic [4:0] POS_START2 = 5'd1;
   localparam logic [4:0] POS_LEN_HI = 5'd2;
   localparam logic [4:0] POS_LEN_LO = 5'd3;
   localparam logic [4:0] POS_DATA   = 5'd4;
   localparam logic [4:0] POS_CK_HI_SHORT = 5'(LEN_SHORT + 16'd2);
   localparam logic [4:0] POS_CK_HI_LONG  = 5'(LEN_LONG + 16'd2);

   localparam logic [3:0] WORD_LAST = 4'(WORD_COUNT - 1);

   // x / 1000 as (x * ceil(2^26 / 1000)) >> 26, exact for 16-bit x
   localparam int HCHO_DIVISOR = 1000;
   localparam int HCHO_SHIFT   = 26;
   localparam int HCHO_RECIP   = ((2 ** HCHO_SHIFT) + HCHO_DIVISOR - 1) / HCHO_DIVISOR;
   localparam int RECIP_W      = $clog2(HCHO_RECIP + 1);

   typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/psfp_front.sv =====
// Frame parser front end: start/length check, running sum, payload store.
// Depends on psfp_pkg; pushes validated frame snapshots to psfp_queue.
module psfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_rx_byte,
   input  logic                  queue_full,
   output logic                  frame_push,
   output psfp_pkg::payload_type frame_data
);
   import psfp_pkg::*;

   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic        long_ff, long_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  ckh_ff, ckh_in;
   payload_type store_ff, store_in;

   logic        accept;
   logic [4:0]  ck_hi_pos;
   logic [4:0]  ck_lo_pos;
   logic [4:0]  data_pos;
   logic [15:0] len_word;
   logic [15:0] sum_add;

   assign ck_hi_pos = long_ff ? POS_CK_HI_LONG : POS_CK_HI_SHORT;
   assign ck_lo_pos = ck_hi_pos + 5'd1;
   assign data_pos  = pos_ff - POS_DATA;
   assign len_word  = {len_hi_ff, req_rx_byte};
   assign sum_add   = sum_ff + {8'd0, req_rx_byte};

   // only the closing checksum byte needs room in the queue
   assign req_full  = queue_full && (pos_ff == ck_lo_pos);
   assign accept    = req_push && !req_full;
   assign frame_data = store_ff;

   always_comb begin
      pos_in     = pos_ff;
      len_hi_in  = len_hi_ff;
      long_in    = long_ff;
      sum_in     = sum_ff;
      ckh_in     = ckh_ff;
      store_in   = store_ff;
      frame_push = 1'b0;
      if (accept) begin
         unique case (pos_ff)
            POS_START1: begin
               if (req_rx_byte == START_FIRST) begin
                  sum_in = {8'd0, req_rx_byte};
                  pos_in = POS_START2;
               end
            end
            POS_START2: begin
               if (req_rx_byte == START_SECOND) begin
                  sum_in = sum_add;
                  pos_in = POS_LEN_HI;
               end else begin
                  pos_in = POS_START1;
               end
            end
            POS_LEN_HI: begin
               sum_in    = sum_add;
               len_hi_in = req_rx_byte;
               pos_in    = POS_LEN_LO;
            end
            POS_LEN_LO: begin
               if (len_word == LEN_SHORT || len_word == LEN_LONG) begin
                  long_in = (len_word == LEN_LONG);
                  sum_in  = sum_add;
                  pos_in  = POS_DATA;
               end else begin
                  pos_in = POS_START1;
               end
            end
            default: begin
               if (pos_ff == ck_hi_pos) begin
                  ckh_in = req_rx_byte;
                  pos_in = pos_ff + 5'd1;
               end else if (pos_ff == ck_lo_pos) begin
                  frame_push = ({ckh_ff, req_rx_byte} == sum_ff);
                  pos_in     = POS_START1;
               end else begin
                  sum_in = sum_add;
                  if ({1'b0, data_pos} < 6'(PAYLOAD_BYTES)) begin
                     store_in[data_pos[PB_IDX_W-1:0]] = req_rx_byte;
                  end
                  pos_in = pos_ff + 5'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_START1;
         len_hi_ff <= 8'd0;
         long_ff   <= 1'b0;
         sum_ff    <= 16'd0;
         ckh_ff    <= 8'd0;
         store_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         len_hi_ff <= len_hi_in;
         long_ff   <= long_in;
         sum_ff    <= sum_in;
         ckh_ff    <= ckh_in;
         store_ff  <= store_in;
      end
   end

endmodule

// ===== src/psfp_queue.sv =====
// Small FIFO of validated frame snapshots between front and back end.
// Depends on psfp_pkg.
module psfp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  psfp_pkg::payload_type       push_data,
   input  logic                        pop,
   output psfp_pkg::payload_type       head_data,
   output psfp_pkg::queue_status_type  status
);
   import psfp_pkg::*;

   payload_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/psfp_back.sv =====
// Back end: walks the 13 words of the head frame into the result register,
// scaling the formaldehyde word by 1/1000. Depends on psfp_pkg.
module psfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  psfp_pkg::payload_type head_data,
   input  logic                  queue_empty,
   output logic                  queue_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [3:0]            rsp_word_index,
   output logic [15:0]           rsp_word_value,
   output logic                  rsp_last_word
);
   import psfp_pkg::*;

   logic [3:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [3:0]  index_ff, index_in;
   logic [15:0] value_ff, value_in;
   logic        last_ff, last_in;

   logic                      load;
   logic                      at_last;
   logic [PB_IDX_W-1:0]       hi_idx;
   logic [PB_IDX_W-1:0]       lo_idx;
   logic [15:0]               word;
   logic [16+RECIP_W-1:0]     product;

   assign at_last = (cnt_ff == WORD_LAST);
   assign load    = !queue_empty && (!valid_ff || rsp_pop);
   assign queue_pop = load && at_last;

   assign hi_idx  = PB_IDX_W'({cnt_ff, 1'b0});
   assign lo_idx  = PB_IDX_W'({cnt_ff, 1'b1});
   assign word    = {head_data[hi_idx], head_data[lo_idx]};
   assign product = {{RECIP_W{1'b0}}, word} * (16 + RECIP_W)'(HCHO_RECIP);

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      index_in = index_ff;
      value_in = value_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         index_in = cnt_ff;
         value_in = at_last ? 16'(product >> HCHO_SHIFT) : word;
         last_in  = at_last;
         cnt_in   = at_last ? 4'd0 : cnt_ff + 4'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_word_index = index_ff;
   assign rsp_word_value = value_ff;
   assign rsp_last_word  = last_ff;

endmodule

// ===== src/particle_sensor_frame_parser_core.sv =====
// Top level of the particle sensor frame parser.
// Depends on psfp_pkg, psfp_front, psfp_queue and psfp_back.
//
// One received byte is taken per clock while req_full is low. A frame whose checksum
// matches yields 13 result words, one per clock from the result register while
// rsp_pop drains them; the first is loaded there after the frame is written to the
// queue. Word 12 is the formaldehyde reading divided by 1000. Validated frames are
// copied into a two-frame queue, so the parser keeps running while results wait;
// req_full rises only on the closing checksum byte, and only while two frames are
// still waiting to be drained. After reset the payload store reads as zero.
module particle_sensor_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_word_index,
   output logic [15:0] rsp_word_value,
   output logic        rsp_last_word
);
   import psfp_pkg::*;

   logic             frame_push;
   payload_type      frame_data;
   payload_type      head_data;
   logic             queue_pop;
   queue_status_type q_status;

   psfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .queue_full  (q_status.full),
      .frame_push  (frame_push),
      .frame_data  (frame_data)
   );

   psfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_data),
      .pop       (queue_pop),
      .head_data (head_data),
      .status    (q_status)
   );

   psfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_data      (head_data),
      .queue_empty    (q_status.empty),
      .queue_pop      (queue_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_word_index (rsp_word_index),
      .rsp_word_value (rsp_word_value),
      .rsp_last_word  (rsp_last_word)
   );

endmodule
